// File: rtl/ngd_pkg.sv
package ngd_pkg;

  // One RGBA pixel; red sits in the lowest byte, so this matches tdata.
  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  // gray_mode codes
  localparam logic [1:0] MODE_PASS     = 2'd0;
  localparam logic [1:0] MODE_BALANCED = 2'd1;
  localparam logic [1:0] MODE_STRONG   = 2'd2;

  // Fade edges per preset
  localparam logic [7:0] BAL_LOW  = 8'd8;
  localparam logic [7:0] BAL_HIGH = 8'd24;
  localparam logic [7:0] STR_LOW  = 8'd16;
  localparam logic [7:0] STR_HIGH = 8'd40;

  // Fade width W = high - low
  localparam logic [4:0] BAL_WIDTH = 5'd16;
  localparam logic [4:0] STR_WIDTH = 5'd24;

  // 3*W
  localparam logic [6:0] BAL_WIDTH3 = 7'd48;
  localparam logic [6:0] STR_WIDTH3 = 7'd72;

  // Denominator D = W^3 and D/2
  localparam logic [13:0] BAL_DEN      = 14'd4096;
  localparam logic [13:0] STR_DEN      = 14'd13824;
  localparam logic [13:0] BAL_DEN_HALF = 14'd2048;
  localparam logic [13:0] STR_DEN_HALF = 14'd6912;

  // Luma weights
  localparam logic [6:0]  LUMA_R     = 7'd38;
  localparam logic [6:0]  LUMA_G     = 7'd75;
  localparam logic [6:0]  LUMA_B     = 7'd15;
  localparam logic [15:0] LUMA_ROUND = 16'd64;
  localparam int          LUMA_SHIFT = 7;

  // Division by D: balanced D = 2^12; strong D = 2^9 * 27.
  localparam int          BAL_DEN_SHIFT = 12;
  localparam int          STR_DEN_SHIFT = 9;
  // x / 27 == (x * 4855) >> 17 for every x below 8192
  localparam logic [12:0] RECIP_27    = 13'd4855;
  localparam int          RECIP_SHIFT = 17;

  // Stage 1 result
  typedef struct packed {
    pixel_t     pix;
    logic       pass;
    logic       strong_sel;
    logic [7:0] spread;
    logic [7:0] luma;
  } stats_t;

  // Stage 3 result
  typedef struct packed {
    pixel_t      pix;
    logic        pass;
    logic        strong_sel;
    logic [7:0]  luma;
    logic [13:0] w;
  } weight_t;

endpackage

// File: rtl/near_gray_desaturate_top.sv
// Channel  | Dir | Beat contents
// s_*      | in  | tdata[31:0]: in_red[7:0], in_green[15:8], in_blue[23:16], in_alpha[31:24]
// m_*      | out | tdata[31:0]: out_red[7:0], out_green[15:8], out_blue[23:16], out_alpha[31:24]
// cfg_*    | in  | cfg_wr_data[1:0]: gray_mode, written when cfg_wr_en is high
//
// One pixel per clock sustained while m_tready stays high.
// Stages: spread/luma, clamp and t*t, weight, products, sum and shift, divide-by-27.
// The multipliers, found in every stage but the fifth, set the stage depth.
// rst (synchronous) clears all stage valid bits and sets gray_mode to pass-through.
// Backpressure: each stage loads when it is empty or its successor loads, so bubbles
// collapse and s_tready stays high while any stage has room; nothing is dropped.
module near_gray_desaturate_top
  import ngd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // in_red, in_green, in_blue, in_alpha (low to high)
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,
  // out_red, out_green, out_blue, out_alpha (low to high)
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data
);

  logic [1:0] gray_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      gray_mode <= MODE_PASS;
    end else if (cfg_wr_en) begin
      gray_mode <= cfg_wr_data;
    end
  end

  // stage 1
  logic   st_valid, st_ready;
  stats_t st;

  ngd_stats u_stats (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_pix    (pixel_t'(s_tdata)),
    .mode      (gray_mode),
    .out_valid (st_valid),
    .out_ready (st_ready),
    .out_stats (st)
  );

  // stages 2-3
  logic    wt_valid, wt_ready;
  weight_t wt;

  ngd_weight u_weight (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (st_valid),
    .in_ready   (st_ready),
    .in_stats   (st),
    .out_valid  (wt_valid),
    .out_ready  (wt_ready),
    .out_weight (wt)
  );

  // stages 4-6, last stage is the output register
  pixel_t out_pix;

  ngd_blend u_blend (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (wt_valid),
    .in_ready  (wt_ready),
    .in_weight (wt),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_pix   (out_pix)
  );

  assign m_tdata = 32'(out_pix);

  // an empty output register means every stage can load
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  // no beat appears right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst && $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");

endmodule

// File: rtl/ngd_stats.sv
module ngd_stats
  import ngd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  pixel_t     in_pix,
  input  logic [1:0] mode,
  output logic       out_valid,
  input  logic       out_ready,
  output stats_t     out_stats
);

  logic [7:0]  max_rg, min_rg, max_c, min_c, spread, high;
  logic [15:0] luma_sum;
  logic        active, strong_sel;
  logic        en;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_comb begin
    max_rg = (in_pix.red > in_pix.green) ? in_pix.red : in_pix.green;
    min_rg = (in_pix.red < in_pix.green) ? in_pix.red : in_pix.green;
    max_c  = (max_rg > in_pix.blue) ? max_rg : in_pix.blue;
    min_c  = (min_rg < in_pix.blue) ? min_rg : in_pix.blue;
    spread = max_c - min_c;

    luma_sum = 16'(LUMA_R) * 16'(in_pix.red)
             + 16'(LUMA_G) * 16'(in_pix.green)
             + 16'(LUMA_B) * 16'(in_pix.blue)
             + LUMA_ROUND;

    unique case (mode)
      MODE_BALANCED: begin
        active     = 1'b1;
        strong_sel = 1'b0;
      end
      MODE_STRONG: begin
        active     = 1'b1;
        strong_sel = 1'b1;
      end
      default: begin
        active     = 1'b0;
        strong_sel = 1'b0;
      end
    endcase
    high = strong_sel ? STR_HIGH : BAL_HIGH;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_stats.pix        <= in_pix;
      out_stats.pass       <= !active || (spread == 8'd0) || (spread >= high);
      out_stats.strong_sel <= strong_sel;
      out_stats.spread     <= spread;
      out_stats.luma       <= luma_sum[LUMA_SHIFT +: 8];
    end
  end

endmodule

// File: rtl/ngd_weight.sv
module ngd_weight
  import ngd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  stats_t  in_stats,
  output logic    out_valid,
  input  logic    out_ready,
  output weight_t out_weight
);

  typedef struct packed {
    pixel_t     pix;
    logic       pass;
    logic       strong_sel;
    logic [7:0] luma;
    logic [9:0] tt;
    logic [6:0] k;
  } cube_t;

  // stage 2: t, t*t and 3W - 2t
  logic       s2_valid, s2_en, s3_en;
  cube_t      s2;
  logic [7:0] low, diff;
  logic [4:0] width, t;
  logic [6:0] width3;

  assign s3_en    = !out_valid || out_ready;
  assign s2_en    = !s2_valid || s3_en;
  assign in_ready = s2_en;

  always_comb begin
    low    = in_stats.strong_sel ? STR_LOW : BAL_LOW;
    width  = in_stats.strong_sel ? STR_WIDTH : BAL_WIDTH;
    width3 = in_stats.strong_sel ? STR_WIDTH3 : BAL_WIDTH3;
    diff   = in_stats.spread - low;
    if (in_stats.spread <= low) begin
      t = 5'd0;
    end else if (diff > 8'(width)) begin
      t = width;
    end else begin
      t = diff[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_en) begin
      s2_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en) begin
      s2.pix        <= in_stats.pix;
      s2.pass       <= in_stats.pass;
      s2.strong_sel <= in_stats.strong_sel;
      s2.luma       <= in_stats.luma;
      s2.tt         <= 10'(t) * 10'(t);
      s2.k          <= width3 - {1'b0, t, 1'b0};
    end
  end

  // stage 3: w = t*t*(3W - 2t), never above D
  logic [16:0] w_full;

  assign w_full = 17'(s2.tt) * 17'(s2.k);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s3_en) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_en) begin
      out_weight.pix        <= s2.pix;
      out_weight.pass       <= s2.pass;
      out_weight.strong_sel <= s2.strong_sel;
      out_weight.luma       <= s2.luma;
      out_weight.w          <= w_full[13:0];
    end
  end

  // weight stays within the denominator of its preset
  a_w_bound: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> (w_full <= (s2.strong_sel ? 17'(STR_DEN) : 17'(BAL_DEN))))
    else $error("smoothstep weight above denominator");

endmodule

// File: rtl/ngd_blend.sv
module ngd_blend
  import ngd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  weight_t in_weight,
  output logic    out_valid,
  input  logic    out_ready,
  output pixel_t  out_pix
);

  logic s4_valid, s5_valid;
  logic s4_en, s5_en, s6_en;

  assign s6_en    = !out_valid || out_ready;
  assign s5_en    = !s5_valid || s6_en;
  assign s4_en    = !s4_valid || s5_en;
  assign in_ready = s4_en;

  // stage 4: base = (D - w)*luma + D/2, and w*channel per color
  pixel_t           s4_pix;
  logic             s4_pass, s4_strong;
  logic [21:0]      s4_base;
  logic [2:0][21:0] s4_prod;
  logic [2:0][7:0]  in_ch;
  logic [13:0]      den, den_half;

  assign in_ch    = {in_weight.pix.blue, in_weight.pix.green, in_weight.pix.red};
  assign den      = in_weight.strong_sel ? STR_DEN : BAL_DEN;
  assign den_half = in_weight.strong_sel ? STR_DEN_HALF : BAL_DEN_HALF;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (s4_en) begin
      s4_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_en) begin
      s4_pix    <= in_weight.pix;
      s4_pass   <= in_weight.pass;
      s4_strong <= in_weight.strong_sel;
      s4_base   <= 22'(den - in_weight.w) * 22'(in_weight.luma) + 22'(den_half);
      for (int k = 0; k < 3; k++) begin
        s4_prod[k] <= 22'(in_weight.w) * 22'(in_ch[k]);
      end
    end
  end

  // stage 5: sum, then the power-of-two part of the division
  pixel_t           s5_pix;
  logic             s5_pass, s5_strong;
  logic [2:0][12:0] s5_x;
  logic [2:0][21:0] num;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      num[k] = s4_base + s4_prod[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (s5_en) begin
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s5_en) begin
      s5_pix    <= s4_pix;
      s5_pass   <= s4_pass;
      s5_strong <= s4_strong;
      for (int k = 0; k < 3; k++) begin
        s5_x[k] <= s4_strong ? num[k][STR_DEN_SHIFT +: 13]
                             : 13'(num[k][BAL_DEN_SHIFT +: 8]);
      end
    end
  end

  // stage 6: divide by 27 through reciprocal, pick bypass or blend
  logic [2:0][25:0] recip;
  logic [2:0][7:0]  quot;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      recip[k] = 26'(s5_x[k]) * 26'(RECIP_27);
      quot[k]  = s5_strong ? recip[k][RECIP_SHIFT +: 8] : s5_x[k][7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s6_en) begin
      out_valid <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s6_en) begin
      out_pix.alpha <= s5_pix.alpha;
      out_pix.red   <= s5_pass ? s5_pix.red   : quot[0];
      out_pix.green <= s5_pass ? s5_pix.green : quot[1];
      out_pix.blue  <= s5_pass ? s5_pix.blue  : quot[2];
    end
  end

  // strong preset: numerator / 512 stays where the reciprocal is exact
  a_recip_range: assert property (@(posedge clk) disable iff (rst)
    s5_valid && s5_strong |->
      (s5_x[0] <= 13'd6899) && (s5_x[1] <= 13'd6899) && (s5_x[2] <= 13'd6899))
    else $error("blend numerator out of reciprocal range");

endmodule

// File: verif/tb_near_gray_desaturate_top.sv
module tb_near_gray_desaturate_top;
  import ngd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The register is 2 bits wide; code 3 has no preset and must behave like pass-through.
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // Cycles with no beat on either side before the run is called hung.
  localparam int STALL_LIMIT = 5000;
  // Drain time after the last result.
  localparam int DRAIN_CYCLES = 20;

  // Expected-pixel store plus the fade predictor. The active gray_mode is
  // mirrored here and sampled when an input beat is accepted.
  class gray_fade_scoreboard;
    pixel_t      fade_q[$];
    logic [1:0]  mode;
    int unsigned errors;

    function new();
      mode   = MODE_PASS;
      errors = 0;
    endfunction

    // Blend each color channel toward luma with a smoothstep weight on spread.
    function pixel_t fade_pixel(pixel_t p);
      int unsigned lo, hi, hi_c, lo_c, spread, wd, den, t, w, luma, base;
      pixel_t      q;
      q = p;
      if (mode == MODE_BALANCED) begin
        lo = BAL_LOW;
        hi = BAL_HIGH;
      end else if (mode == MODE_STRONG) begin
        lo = STR_LOW;
        hi = STR_HIGH;
      end else begin
        return q;
      end
      hi_c = p.red;
      if (p.green > hi_c) hi_c = p.green;
      if (p.blue > hi_c) hi_c = p.blue;
      lo_c = p.red;
      if (p.green < lo_c) lo_c = p.green;
      if (p.blue < lo_c) lo_c = p.blue;
      spread = hi_c - lo_c;
      // Pure gray and clearly colored pixels are left alone.
      if (spread == 0 || spread >= hi) return q;
      wd   = hi - lo;
      den  = wd * wd * wd;
      luma = (38 * p.red + 75 * p.green + 15 * p.blue + 64) / 128;
      t    = (spread > lo) ? spread - lo : 0;
      if (t > wd) t = wd;
      w    = t * t * (3 * wd - 2 * t);
      base = (den - w) * luma + den / 2;
      q.red   = 8'((base + w * p.red) / den);
      q.green = 8'((base + w * p.green) / den);
      q.blue  = 8'((base + w * p.blue) / den);
      return q;
    endfunction

    function void note_pixel(pixel_t p);
      fade_q.push_back(fade_pixel(p));
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (fade_q.size() == 0) begin
        $display("%0t: unexpected output beat %h", $time, got);
        errors++;
        return;
      end
      want = fade_q.pop_front();
      if (got.red !== want.red) begin
        $display("%0t: red expected %0d actual %0d", $time, want.red, got.red);
        errors++;
      end
      if (got.green !== want.green) begin
        $display("%0t: green expected %0d actual %0d", $time, want.green, got.green);
        errors++;
      end
      if (got.blue !== want.blue) begin
        $display("%0t: blue expected %0d actual %0d", $time, want.blue, got.blue);
        errors++;
      end
      if (got.alpha !== want.alpha) begin
        $display("%0t: alpha expected %0d actual %0d", $time, want.alpha, got.alpha);
        errors++;
      end
    endfunction

    function int pending();
      return fade_q.size();
    endfunction
  endclass

  // Every input has a known value from time zero.
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;       // in_red, in_green, in_blue, in_alpha (low to high)
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;            // out_red, out_green, out_blue, out_alpha (low to high)
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_wr_data = MODE_PASS;

  gray_fade_scoreboard sb = new();

  // Idle rates in percent; changed per phase by the stimulus thread.
  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  int unsigned quiet_cycles = 0;

  near_gray_desaturate_top dut (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // Receiver: random stalls at the current rate, one decision per cycle.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
  end

  // Monitor. Input beats are noted before output beats of the same edge, so
  // ordering inside the edge never matters; values are the pre-edge ones.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_pixel(s_tdata);
      if (m_tvalid && m_tready) sb.check_pixel(m_tdata);
    end
  end

  // Watchdog: count consecutive cycles without any beat.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no beat for %0d cycles, %0d pixels outstanding",
                 STALL_LIMIT, sb.pending());
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Present one pixel, with random idle cycles ahead of it, and hold it until
  // accepted. tvalid is left high so back-to-back beats need no re-raise.
  task automatic send_pixel(input pixel_t p);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= p;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_rgba(input logic [7:0] r, g, b, a);
    pixel_t p;
    p.red   = r;
    p.green = g;
    p.blue  = b;
    p.alpha = a;
    send_pixel(p);
  endtask

  // Mode change only with the pipe empty: drop tvalid, drain, then one write.
  // The extra edge lets the monitor note the last accepted beat first.
  task automatic set_mode(input logic [1:0] m);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.mode = m;
  endtask

  // Mostly near-gray pixels (spread around both fade windows), some arbitrary.
  function automatic pixel_t near_gray_pixel();
    int unsigned s, lo_v, c[3], j, tmp;
    pixel_t      p;
    s    = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 45) : $urandom_range(0, 255);
    lo_v = $urandom_range(0, 255 - s);
    c[0] = lo_v;
    c[1] = lo_v + s;
    c[2] = $urandom_range(lo_v, lo_v + s);
    // shuffle which channel holds min, max and middle
    for (int i = 2; i > 0; i--) begin
      j    = $urandom_range(0, i);
      tmp  = c[i];
      c[i] = c[j];
      c[j] = tmp;
    end
    p.red   = 8'(c[0]);
    p.green = 8'(c[1]);
    p.blue  = 8'(c[2]);
    p.alpha = 8'($urandom_range(0, 255));
    return p;
  endfunction

  task automatic run_random(input logic [1:0] m, input int n);
    set_mode(m);
    repeat (n) send_pixel(near_gray_pixel());
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: balanced window edges, low 8 / high 24.
    set_mode(MODE_BALANCED);
    send_rgba(8'd0,   8'd0,   8'd0,   8'd0);    // black, spread zero
    send_rgba(8'd255, 8'd255, 8'd255, 8'd255);  // white, spread zero
    send_rgba(8'd100, 8'd101, 8'd100, 8'h5a);   // spread 1: full luma
    send_rgba(8'd50,  8'd57,  8'd52,  8'ha5);   // just under low
    send_rgba(8'd50,  8'd58,  8'd52,  8'h01);   // spread equals low
    send_rgba(8'd30,  8'd46,  8'd38,  8'h80);   // mid window
    send_rgba(8'd200, 8'd177, 8'd190, 8'h7f);   // one below high
    send_rgba(8'd10,  8'd34,  8'd20,  8'hfe);   // spread equals high: pass
    send_rgba(8'd0,   8'd255, 8'd0,   8'h33);   // maximum spread
    send_rgba(8'd255, 8'd0,   8'd128, 8'hcc);

    // Directed: strong window, low 16 / high 40.
    set_mode(MODE_STRONG);
    send_rgba(8'd120, 8'd136, 8'd128, 8'h10);   // spread equals low
    send_rgba(8'd0,   8'd17,  8'd5,   8'h20);   // just above low
    send_rgba(8'd216, 8'd255, 8'd240, 8'h40);   // one below high
    send_rgba(8'd215, 8'd255, 8'd240, 8'h08);   // spread equals high
    send_rgba(8'd60,  8'd88,  8'd70,  8'h04);   // mid window
    send_rgba(8'd128, 8'd128, 8'd128, 8'h02);   // gray

    // Pass-through and the unused code.
    set_mode(MODE_PASS);
    send_rgba(8'd70,  8'd80,  8'd75,  8'hff);
    send_rgba(8'd255, 8'd0,   8'd255, 8'h00);
    set_mode(MODE_UNUSED);
    send_rgba(8'd70,  8'd80,  8'd75,  8'h55);
    send_rgba(8'd1,   8'd0,   8'd1,   8'haa);

    // Random: three idle profiles, each sweeping the presets.
    for (int prof = 0; prof < 3; prof++) begin
      case (prof)
        0: begin
          src_idle_pct = 6;
          snk_idle_pct = 53;
        end
        1: begin
          src_idle_pct = 53;
          snk_idle_pct = 6;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
      endcase
      run_random(MODE_BALANCED, 280);
      run_random(MODE_STRONG, 280);
      run_random((prof == 1) ? MODE_UNUSED : MODE_PASS, 60);
    end

    // Let everything drain, then watch a little longer for stray beats.
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: near_gray_desaturate_top.f
rtl/ngd_pkg.sv
rtl/ngd_stats.sv
rtl/ngd_weight.sv
rtl/ngd_blend.sv
rtl/near_gray_desaturate_top.sv
verif/tb_near_gray_desaturate_top.sv
